/* hdl/dccs_pkg.sv */
// ----------------------------------------------------------------------------
// dccs_pkg
// Shared sizes, register codes, reset values and interface types of the
// deficit-corrected category sampler.
// ----------------------------------------------------------------------------
package dccs_pkg;

  // Sizing of the block.
  localparam int MAX_CATEGORIES  = 6;
  localparam int COUNT_BITS      = 24;
  localparam int NUM_WEIGHT_REGS = 6;
  localparam int NUM_REGS        = 2 + NUM_WEIGHT_REGS;

  // Fixed field widths.
  localparam int WEIGHT_W = 16;
  localparam int RAND_W   = 16;
  localparam int CATCNT_W = 3;
  localparam int WARMUP_W = 8;
  localparam int CHOSEN_W = 3;
  localparam int DATA_W   = 32;

  // Register port addressing: one word per register.
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int ADDR_W    = REG_IDX_W + 2;

  // Derived datapath widths.
  localparam int IDX_W       = $clog2(MAX_CATEGORIES);
  localparam int WSUM_W      = WEIGHT_W + $clog2(MAX_CATEGORIES);
  localparam int PROD_W      = COUNT_BITS + WSUM_W;
  localparam int DEF_W       = WEIGHT_W + COUNT_BITS;
  localparam int DSUM_W      = DEF_W + $clog2(MAX_CATEGORIES);
  localparam int NCHUNK      = (DSUM_W + COUNT_BITS - 1) / COUNT_BITS;
  localparam int CHUNK_IDX_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int VPAD_W      = NCHUNK * COUNT_BITS;
  localparam int ACC_W       = VPAD_W + RAND_W;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_CATEGORY_COUNT = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_WARMUP_DRAWS   = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_BASE    = REG_IDX_W'(2);

  // Reset values.
  localparam logic [CATCNT_W-1:0] CATCNT_RESET = CATCNT_W'(5);
  localparam logic [WARMUP_W-1:0] WARMUP_RESET = WARMUP_W'(10);

  // Input field codes.
  localparam logic MODE_DRAW  = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef logic [MAX_CATEGORIES-1:0][WEIGHT_W-1:0] weight_vec_t;

  // Configuration seen by the sequencer.
  typedef struct packed {
    logic [CATCNT_W-1:0] category_count;
    logic [WARMUP_W-1:0] warmup_draws;
    weight_vec_t         weights;
  } cfg_t;

  // Operands for the shared multiplier.
  typedef struct packed {
    logic [COUNT_BITS-1:0] a;
    logic [WSUM_W-1:0]     b;
  } mul_op_t;

  // Reset value of the weight of category k.
  function automatic logic [WEIGHT_W-1:0] weight_reset(int k);
    logic [WEIGHT_W-1:0] val;
    unique case (k)
      0:       val = WEIGHT_W'(1);
      1:       val = WEIGHT_W'(2);
      2:       val = WEIGHT_W'(3);
      3:       val = WEIGHT_W'(2);
      4:       val = WEIGHT_W'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

/* hdl/deficit_corrected_category_sampler.sv */
// ----------------------------------------------------------------------------
// deficit_corrected_category_sampler
// Draws a category by inverse CDF over desired weights or count deficits.
//
// The input channel takes items of mode and random_value; the output channel
// returns chosen_category, used_correction and count_saturated, one result
// item per input item. Both channels use valid and ready.
// Configuration (category count, warm-up length, six weights) is written over
// the APB-style port at byte address 4*i. The user must write it only while the
// block is idle; the block itself does not enforce this. A draw item is
// accepted; the sequencer sums the weights one category at a time, decides,
// and when correction applies forms each deficit as the clipped difference
// of w_i * C and c_i * W. It scales the random fraction, walks the CDF to
// the chosen category and posts the result, stepping one shared registered
// multiplier over the categories and over the two chunks of the scaled total.
// Reset zeroes every tally and the total and loads the register defaults.
// The result waits in an output register; the next item is accepted while it
// waits, but that item completes only once the receiver has taken the result.
// ----------------------------------------------------------------------------
module deficit_corrected_category_sampler (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dccs_pkg::ADDR_W-1:0]   paddr,
  input  logic [dccs_pkg::DATA_W-1:0]   pwdata,
  output logic [dccs_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [dccs_pkg::RAND_W-1:0]   random_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [dccs_pkg::CHOSEN_W-1:0] chosen_category_o,
  output logic                         used_correction_o,
  output logic                         count_saturated_o
);
  import dccs_pkg::*;

  cfg_t              cfg;
  mul_op_t           mul_op;
  logic [PROD_W-1:0] prod;

  // Configuration registers.
  dccs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Shared multiplier.
  dccs_mul u_mul (
    .clk_i  (clk_i),
    .op_i   (mul_op),
    .prod_o (prod)
  );

  // Sequencer, tallies and result register.
  dccs_seq u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .random_value_i    (random_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .chosen_category_o (chosen_category_o),
    .used_correction_o (used_correction_o),
    .count_saturated_o (count_saturated_o),
    .mul_op_o          (mul_op),
    .prod_i            (prod)
  );

endmodule

/* hdl/dccs_cfg.sv */
// ----------------------------------------------------------------------------
// dccs_cfg
// Register file behind the APB-style configuration port: category count,
// warm-up length and the desired weights.
// ----------------------------------------------------------------------------
module dccs_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dccs_pkg::ADDR_W-1:0] paddr,
  input  logic [dccs_pkg::DATA_W-1:0] pwdata,
  output logic [dccs_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output dccs_pkg::cfg_t             cfg_o
);
  import dccs_pkg::*;

  logic [CATCNT_W-1:0]  catcnt_q;
  logic [WARMUP_W-1:0]  warmup_q;
  weight_vec_t          weights_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [REG_IDX_W-1:0] widx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign widx    = reg_idx - REG_WEIGHT_BASE;
  assign wr_en   = psel && penable && pwrite;

  // Register writes; a weight is stored even beyond the categories in use.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      catcnt_q <= CATCNT_RESET;
      warmup_q <= WARMUP_RESET;
      for (int k = 0; k < MAX_CATEGORIES; k++) begin
        weights_q[k] <= weight_reset(k);
      end
    end else if (wr_en) begin
      priority if (reg_idx == REG_CATEGORY_COUNT) begin
        catcnt_q <= pwdata[CATCNT_W-1:0];
      end else if (reg_idx == REG_WARMUP_DRAWS) begin
        warmup_q <= pwdata[WARMUP_W-1:0];
      end else begin
        for (int k = 0; k < MAX_CATEGORIES; k++) begin
          if (k < NUM_WEIGHT_REGS && widx == REG_IDX_W'(k)) begin
            weights_q[k] <= pwdata[WEIGHT_W-1:0];
          end
        end
      end
    end
  end

  // Read-back of the addressed register.
  always_comb begin
    prdata = '0;
    priority if (reg_idx == REG_CATEGORY_COUNT) begin
      prdata = DATA_W'(catcnt_q);
    end else if (reg_idx == REG_WARMUP_DRAWS) begin
      prdata = DATA_W'(warmup_q);
    end else begin
      for (int k = 0; k < MAX_CATEGORIES; k++) begin
        if (k < NUM_WEIGHT_REGS && widx == REG_IDX_W'(k)) begin
          prdata = DATA_W'(weights_q[k]);
        end
      end
    end
  end

  assign cfg_o.category_count = catcnt_q;
  assign cfg_o.warmup_draws   = warmup_q;
  assign cfg_o.weights        = weights_q;

endmodule

/* hdl/dccs_mul.sv */
// ----------------------------------------------------------------------------
// dccs_mul
// Shared multiplier with a registered product; the product of the operands
// presented in one cycle is available in the next.
// ----------------------------------------------------------------------------
module dccs_mul (
  input  logic                       clk_i,
  input  dccs_pkg::mul_op_t          op_i,
  output logic [dccs_pkg::PROD_W-1:0] prod_o
);
  import dccs_pkg::*;

  logic [PROD_W-1:0] prod_q;

  // One COUNT_BITS by WSUM_W product per cycle.
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(op_i.a) * PROD_W'(op_i.b);
  end

  assign prod_o = prod_q;

endmodule

/* hdl/dccs_seq.sv */
// ----------------------------------------------------------------------------
// dccs_seq
// Sequencer and datapath of the sampler: weight sum, per-category deficits,
// scaling of the random fraction, inverse-CDF walk and tally update.
// ----------------------------------------------------------------------------
module dccs_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dccs_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [dccs_pkg::RAND_W-1:0]   random_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [dccs_pkg::CHOSEN_W-1:0] chosen_category_o,
  output logic                         used_correction_o,
  output logic                         count_saturated_o,
  output dccs_pkg::mul_op_t            mul_op_o,
  input  logic [dccs_pkg::PROD_W-1:0]   prod_i
);
  import dccs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WSUM,
    ST_DECIDE,
    ST_DEF_WANT,
    ST_DEF_HAVE,
    ST_DEF_DIFF,
    ST_SCALE_MUL,
    ST_SCALE_ACC,
    ST_CDF,
    ST_UPDATE,
    ST_CLEAR
  } state_e;

  // Control state.
  state_e                 state_q, state_d;
  logic [IDX_W-1:0]       i_q, i_d;
  logic [CHUNK_IDX_W-1:0] chunk_q, chunk_d;
  logic                   out_valid_q, out_valid_d;
  logic [CHOSEN_W-1:0]    chosen_q, chosen_d;
  logic                   used_q, used_d;
  logic                   sat_q, sat_d;
  logic [COUNT_BITS-1:0]  tally_q [MAX_CATEGORIES];
  logic [COUNT_BITS-1:0]  tally_d [MAX_CATEGORIES];
  logic [COUNT_BITS-1:0]  total_q, total_d;

  // Working registers of the current item.
  logic [IDX_W-1:0]       last_q, last_d;
  logic [IDX_W-1:0]       pick_q, pick_d;
  logic [RAND_W-1:0]      rnd_q, rnd_d;
  logic [WSUM_W-1:0]      wsum_q, wsum_d;
  logic [DEF_W-1:0]       want_q, want_d;
  logic [DEF_W-1:0]       def_q [MAX_CATEGORIES];
  logic [DEF_W-1:0]       def_d [MAX_CATEGORIES];
  logic [DSUM_W-1:0]      dsum_q, dsum_d;
  logic [DSUM_W-1:0]      vtot_q, vtot_d;
  logic                   corr_q, corr_d;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [DSUM_W-1:0]      cum_q, cum_d;

  // Helpers.
  logic [WEIGHT_W-1:0]    w_sel;
  logic [IDX_W-1:0]       last_in;
  logic [VPAD_W-1:0]      vpad;
  logic [DSUM_W-1:0]      cdf_val;
  logic [DSUM_W-1:0]      cum_next;
  logic                   cdf_hit;
  logic [DEF_W-1:0]       diff;
  logic [DSUM_W-1:0]      dsum_next;
  logic                   slot_free;
  logic                   use_deficit;
  logic [COUNT_BITS-1:0]  total_inc;

  assign w_sel     = cfg_i.weights[i_q];
  assign vpad      = VPAD_W'(vtot_q);
  assign cdf_val   = corr_q ? DSUM_W'(def_q[i_q]) : DSUM_W'(w_sel);
  assign cum_next  = cum_q + cdf_val;
  assign cdf_hit   = acc_q < ACC_W'({cum_next, {RAND_W{1'b0}}});
  assign diff      = (PROD_W'(want_q) > prod_i) ? DEF_W'(PROD_W'(want_q) - prod_i) : '0;
  assign dsum_next = dsum_q + DSUM_W'(diff);
  assign slot_free = !out_valid_q || out_ready_i;
  assign use_deficit = (total_q != '0) && (total_q >= COUNT_BITS'(cfg_i.warmup_draws));
  assign total_inc = (total_q != '1) ? total_q + COUNT_BITS'(1) : total_q;

  // Clamp the category count to one .. MAX_CATEGORIES, as the last index.
  always_comb begin
    priority if (cfg_i.category_count == '0) begin
      last_in = '0;
    end else if (int'(cfg_i.category_count) > MAX_CATEGORIES) begin
      last_in = IDX_W'(MAX_CATEGORIES - 1);
    end else begin
      last_in = IDX_W'(cfg_i.category_count - CATCNT_W'(1));
    end
  end

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    chunk_d     = chunk_q;
    out_valid_d = out_valid_q && !out_ready_i;
    chosen_d    = chosen_q;
    used_d      = used_q;
    sat_d       = sat_q;
    tally_d     = tally_q;
    total_d     = total_q;
    last_d      = last_q;
    pick_d      = pick_q;
    rnd_d       = rnd_q;
    wsum_d      = wsum_q;
    want_d      = want_q;
    def_d       = def_q;
    dsum_d      = dsum_q;
    vtot_d      = vtot_q;
    corr_d      = corr_q;
    acc_d       = acc_q;
    cum_d       = cum_q;
    mul_op_o.a  = total_q;
    mul_op_o.b  = WSUM_W'(w_sel);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          rnd_d  = random_value_i;
          last_d = last_in;
          i_d    = '0;
          wsum_d = '0;
          state_d = (mode_i == MODE_CLEAR) ? ST_CLEAR : ST_WSUM;
        end
      end

      // Sum of the weights in use, one category a cycle.
      ST_WSUM: begin
        wsum_d = wsum_q + WSUM_W'(w_sel);
        if (i_q == last_q) begin
          state_d = ST_DECIDE;
        end else begin
          i_d = i_q + IDX_W'(1);
        end
      end

      // Deficits only after warm-up and with a non-zero total.
      ST_DECIDE: begin
        i_d    = '0;
        dsum_d = '0;
        if (use_deficit) begin
          state_d = ST_DEF_WANT;
        end else begin
          corr_d  = 1'b0;
          vtot_d  = DSUM_W'(wsum_q);
          chunk_d = CHUNK_IDX_W'(NCHUNK - 1);
          acc_d   = '0;
          state_d = ST_SCALE_MUL;
        end
      end

      // Issue w_i * C.
      ST_DEF_WANT: begin
        mul_op_o.a = total_q;
        mul_op_o.b = WSUM_W'(w_sel);
        state_d    = ST_DEF_HAVE;
      end

      // Keep w_i * C and issue c_i * W.
      ST_DEF_HAVE: begin
        want_d     = DEF_W'(prod_i);
        mul_op_o.a = tally_q[i_q];
        mul_op_o.b = wsum_q;
        state_d    = ST_DEF_DIFF;
      end

      // Clipped difference, accumulated into the deficit sum.
      ST_DEF_DIFF: begin
        def_d[i_q] = diff;
        dsum_d     = dsum_next;
        if (i_q == last_q) begin
          corr_d  = (dsum_next != '0);
          vtot_d  = (dsum_next != '0) ? dsum_next : DSUM_W'(wsum_q);
          chunk_d = CHUNK_IDX_W'(NCHUNK - 1);
          acc_d   = '0;
          state_d = ST_SCALE_MUL;
        end else begin
          i_d     = i_q + IDX_W'(1);
          state_d = ST_DEF_WANT;
        end
      end

      // random_value * V, one COUNT_BITS chunk of V at a time, top first.
      ST_SCALE_MUL: begin
        mul_op_o.a = vpad[chunk_q*COUNT_BITS +: COUNT_BITS];
        mul_op_o.b = WSUM_W'(rnd_q);
        state_d    = ST_SCALE_ACC;
      end

      ST_SCALE_ACC: begin
        acc_d = (acc_q << COUNT_BITS) + ACC_W'(prod_i);
        if (chunk_q == '0) begin
          i_d     = '0;
          cum_d   = '0;
          state_d = ST_CDF;
        end else begin
          chunk_d = chunk_q - CHUNK_IDX_W'(1);
          state_d = ST_SCALE_MUL;
        end
      end

      // Inverse-CDF walk; the last category catches everything left.
      ST_CDF: begin
        cum_d = cum_next;
        if (cdf_hit || i_q == last_q) begin
          pick_d  = i_q;
          state_d = ST_UPDATE;
        end else begin
          i_d = i_q + IDX_W'(1);
        end
      end

      // Count the draw unless saturated, and post the result item.
      ST_UPDATE: begin
        if (slot_free) begin
          if (total_q != '1) begin
            tally_d[pick_q] = tally_q[pick_q] + COUNT_BITS'(1);
          end
          total_d     = total_inc;
          chosen_d    = CHOSEN_W'(pick_q);
          used_d      = corr_q;
          sat_d       = (total_inc == '1);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      // Zero all tallies; the result item carries zeros.
      ST_CLEAR: begin
        if (slot_free) begin
          for (int k = 0; k < MAX_CATEGORIES; k++) begin
            tally_d[k] = '0;
          end
          total_d     = '0;
          chosen_d    = '0;
          used_d      = 1'b0;
          sat_d       = 1'b0;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, tallies and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
      chosen_q    <= '0;
      used_q      <= 1'b0;
      sat_q       <= 1'b0;
      total_q     <= '0;
      for (int k = 0; k < MAX_CATEGORIES; k++) begin
        tally_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      chunk_q     <= chunk_d;
      out_valid_q <= out_valid_d;
      chosen_q    <= chosen_d;
      used_q      <= used_d;
      sat_q       <= sat_d;
      total_q     <= total_d;
      tally_q     <= tally_d;
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    pick_q <= pick_d;
    rnd_q  <= rnd_d;
    wsum_q <= wsum_d;
    want_q <= want_d;
    def_q  <= def_d;
    dsum_q <= dsum_d;
    vtot_q <= vtot_d;
    corr_q <= corr_d;
    acc_q  <= acc_d;
    cum_q  <= cum_d;
  end

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign chosen_category_o = chosen_q;
  assign used_correction_o = used_q;
  assign count_saturated_o = sat_q;

endmodule
